// File: design/assert_macros.svh
// Assertion macros for the checker file of the life automaton block.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge out of reset.
`define GLAG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define GLAG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/glag_pkg.sv
// Shared types, constants and helper functions of the life automaton block.
// No dependencies; glag_row, glag_ram, the top level and the checker use it.
`timescale 1ns / 1ps

package glag_pkg;

  // Grid geometry
  localparam int MaxRows = 64;
  localparam int MaxCols = 64;
  localparam int AddrW   = $clog2(MaxRows);
  localparam int CntW    = $clog2(MaxRows + 1);
  localparam int WidthW  = 7;
  localparam int GenW    = 16;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 16;

  typedef logic [MaxCols-1:0] row_t;
  typedef logic [AddrW-1:0]   addr_t;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgGenerations = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRowWidth    = 2'd1;

  // Sequencer states
  typedef enum logic [2:0] {
    StLoad,
    StPrime,
    StFetch,
    StSweep,
    StEmitPrime,
    StEmit
  } glag_state_e;

  // Grid memory write port
  typedef struct packed {
    logic  en;
    addr_t addr;
    row_t  data;
  } ram_wr_t;

  // Grid memory read port
  typedef struct packed {
    logic  en;
    addr_t addr;
  } ram_rd_t;

  // Columns below the effective width are live, the rest read as dead.
  function automatic row_t width_mask(input logic [WidthW-1:0] w);
    row_t m;
    m = '0;
    for (int c = 0; c < MaxCols; c++) begin
      m[c] = (WidthW'(c) < w);
    end
    return m;
  endfunction

endpackage

// File: design/glag_cell.sv
// One cell lane: counts the eight neighbors and applies the B3/S23 rule.
// Does not depend on glag_pkg; no types needed.
`timescale 1ns / 1ps

module glag_cell (
  input  logic [7:0] nbr_i,
  input  logic       alive_i,
  output logic       next_o
);

  logic [3:0] cnt;

  // Count live neighbors
  always_comb begin
    cnt = '0;
    for (int i = 0; i < 8; i++) begin
      cnt = cnt + 4'(nbr_i[i]);
    end
  end

  // Born on three, survive on two or three
  assign next_o = (cnt == 4'd3) || ((cnt == 4'd2) && alive_i);

endmodule

// File: design/glag_row.sv
// Row update: one cell lane per column, then merge the lane results under the width mask.
// Depends on glag_pkg (row_t, MaxCols) and glag_cell.
`timescale 1ns / 1ps

module glag_row (
  input  glag_pkg::row_t up_i,
  input  glag_pkg::row_t cur_i,
  input  glag_pkg::row_t down_i,
  input  glag_pkg::row_t mask_i,
  output glag_pkg::row_t next_o
);
  import glag_pkg::*;

  row_t up_l, up_r, cur_l, cur_r, dn_l, dn_r;
  row_t lane_out;

  // Shift neighbor rows; dead cells enter at the edges
  assign up_l  = up_i << 1;
  assign up_r  = up_i >> 1;
  assign cur_l = cur_i << 1;
  assign cur_r = cur_i >> 1;
  assign dn_l  = down_i << 1;
  assign dn_r  = down_i >> 1;

  // One lane per column
  for (genvar c = 0; c < MaxCols; c++) begin : g_lane
    glag_cell u_cell (
      .nbr_i   ({up_l[c], up_i[c], up_r[c], cur_l[c], cur_r[c],
                 dn_l[c], down_i[c], dn_r[c]}),
      .alive_i (cur_i[c]),
      .next_o  (lane_out[c])
    );
  end

  // Merge lanes, drop columns beyond the width
  assign next_o = lane_out & mask_i;

endmodule

// File: design/glag_ram.sv
// Grid memory: one write port and one enabled read port with registered data.
// Depends on glag_pkg (ram_wr_t, ram_rd_t, row_t, MaxRows).
`timescale 1ns / 1ps

module glag_ram (
  input  logic              clk_i,
  input  glag_pkg::ram_wr_t wr_i,
  input  glag_pkg::ram_rd_t rd_i,
  output glag_pkg::row_t    rdata_o
);
  import glag_pkg::*;

  row_t mem [MaxRows];
  row_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // Read port, data holds while not enabled
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_q <= mem[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/life_automaton_generations_unit.sv
// Conway life (B3/S23) on a grid of up to 64 rows by 64 columns, dead border.
// Rows load one per cycle; the row flagged last starts the evolution, or the
// emission when the generation count is zero. Each generation primes the read
// pipeline in StPrime and StFetch, then sweeps the stored rows through the grid
// memory at one row per cycle, bound by the single read port of the grid memory.
// Emission primes the read in StEmitPrime, then gives one row per cycle while
// the output side is ready. No new row is taken from the end of loading
// until the last result row is delivered. Memory needs no clearing after reset.
// Depends on glag_pkg, glag_ram and glag_row.
`timescale 1ns / 1ps

module life_automaton_generations_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Row input
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  glag_pkg::row_t                  row_cells_i,
  input  logic                            row_last_i,
  // Row output
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output glag_pkg::row_t                  result_cells_o,
  output logic                            result_last_o,
  // Configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [glag_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [glag_pkg::CfgDataW-1:0]   cfg_data_i
);
  import glag_pkg::*;

  glag_state_e state_q, state_d;

  logic [GenW-1:0]   generations_q;
  logic [WidthW-1:0] row_width_q;
  logic [CntW-1:0]   rows_q, rows_d;
  logic [GenW-1:0]   gen_left_q, gen_left_d;
  addr_t             last_idx_q, last_idx_d;
  addr_t             r_q, r_d;
  row_t              mask_q, mask_d;
  row_t              prev_q, prev_d;
  row_t              cur_q, cur_d;

  row_t    cur_mask;
  row_t    rdata;
  row_t    rdata_m;
  row_t    down;
  row_t    next_row;
  ram_wr_t wr;
  ram_rd_t rd;
  logic    in_acc;
  logic    at_last;

  assign cur_mask = width_mask(row_width_q);
  assign rdata_m  = rdata & mask_q;
  assign at_last  = (r_q == last_idx_q);
  assign down     = at_last ? '0 : rdata_m;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      generations_q <= '0;
      row_width_q   <= WidthW'(MaxCols);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgGenerations: generations_q <= cfg_data_i;
        CfgRowWidth:    row_width_q   <= cfg_data_i[WidthW-1:0];
        default: ;
      endcase
    end
  end

  // Grid memory
  glag_ram u_ram (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .rd_i    (rd),
    .rdata_o (rdata)
  );

  // Cell lanes for the row under update
  glag_row u_row (
    .up_i   (prev_q),
    .cur_i  (cur_q),
    .down_i (down),
    .mask_i (mask_q),
    .next_o (next_row)
  );

  // Sequencer: next state, memory ports and handshakes
  always_comb begin
    state_d    = state_q;
    rows_d     = rows_q;
    gen_left_d = gen_left_q;
    last_idx_d = last_idx_q;
    r_d        = r_q;
    mask_d     = mask_q;
    prev_d     = prev_q;
    cur_d      = cur_q;
    wr         = '0;
    rd         = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    in_acc      = 1'b0;

    unique case (state_q)
      StLoad: begin
        in_ready_o = 1'b1;
        in_acc     = in_valid_i;
        if (in_acc) begin
          // Store while there is room, drop extra rows
          if (!rows_q[CntW-1]) begin
            wr.en   = 1'b1;
            wr.addr = rows_q[AddrW-1:0];
            wr.data = row_cells_i & cur_mask;
            rows_d  = rows_q + CntW'(1);
          end
          if (row_last_i) begin
            mask_d     = cur_mask;
            last_idx_d = rows_q[CntW-1] ? addr_t'(MaxRows - 1) : rows_q[AddrW-1:0];
            rows_d     = '0;
            gen_left_d = generations_q;
            state_d    = (generations_q == '0) ? StEmitPrime : StPrime;
          end
        end
      end

      StPrime: begin
        rd.en   = 1'b1;
        rd.addr = '0;
        prev_d  = '0;
        r_d     = '0;
        state_d = StFetch;
      end

      StFetch: begin
        cur_d   = rdata_m;
        rd.en   = 1'b1;
        rd.addr = addr_t'(1);
        state_d = StSweep;
      end

      StSweep: begin
        // Write the new row in place, slide the window down
        wr.en   = 1'b1;
        wr.addr = r_q;
        wr.data = next_row;
        prev_d  = cur_q;
        cur_d   = down;
        rd.en   = 1'b1;
        rd.addr = r_q + addr_t'(2);
        r_d     = r_q + addr_t'(1);
        if (at_last) begin
          gen_left_d = gen_left_q - GenW'(1);
          state_d    = (gen_left_q == GenW'(1)) ? StEmitPrime : StPrime;
        end
      end

      StEmitPrime: begin
        rd.en   = 1'b1;
        rd.addr = '0;
        r_d     = '0;
        state_d = StEmit;
      end

      StEmit: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (at_last) begin
            state_d = StLoad;
          end else begin
            rd.en   = 1'b1;
            rd.addr = r_q + addr_t'(1);
            r_d     = r_q + addr_t'(1);
          end
        end
      end

      default: state_d = StLoad;
    endcase
  end

  assign result_cells_o = rdata_m;
  assign result_last_o  = at_last;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StLoad;
      rows_q     <= '0;
      gen_left_q <= '0;
      last_idx_q <= '0;
      r_q        <= '0;
    end else begin
      state_q    <= state_d;
      rows_q     <= rows_d;
      gen_left_q <= gen_left_d;
      last_idx_q <= last_idx_d;
      r_q        <= r_d;
    end
  end

  // Row window and mask
  always_ff @(posedge clk_i) begin
    mask_q <= mask_d;
    prev_q <= prev_d;
    cur_q  <= cur_d;
  end

endmodule

// File: design/glag_checker.sv
// Port-level checks of the life automaton block, bound to its top level.
// Depends on assert_macros.svh and glag_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module glag_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          row_last_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input glag_pkg::row_t                result_cells_o,
  input logic                          result_last_o
);

  logic in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // Loading and emitting never overlap
  `GLAG_ASSERT(a_no_overlap, !(in_ready_o && out_valid_o), "input ready while emitting")

  // A stalled result item holds its payload
  `GLAG_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(result_cells_o) && $stable(result_last_o), "stalled item changed")

  // Closing the grid drops input ready after the last row is taken
  `GLAG_ASSERT_NEXT(a_close, in_acc && row_last_i, !in_ready_o, "input taken after last row")

  // The final result row ends the emission
  `GLAG_ASSERT_NEXT(a_end, out_acc && result_last_o, !out_valid_o, "items after final row")

endmodule

bind life_automaton_generations_unit glag_checker u_glag_checker (.*);
